// ----- hw/rtl/mrme_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrme_pkg
// Shared types and constants of the memory region map engine.
// ----------------------------------------------------------------------------
package mrme_pkg;

    localparam int MRME_MAX_REGIONS = 256;

    localparam int S_TDATA_W = 208;
    localparam int M_TDATA_W = 176;

    localparam logic [31:0] USABLE_TYPE      = 32'd1;
    localparam logic [63:0] BUMP_RESET       = 64'h0000_0000_0010_0000;
    localparam logic [4:0]  PAGE_SHIFT_RESET = 5'd12;
    localparam logic [31:0] LOW_FLOOR_RESET  = 32'h0010_0000;

    // Command codes.
    localparam logic [2:0] CMD_ADD   = 3'd0;
    localparam logic [2:0] CMD_SAN   = 3'd1;
    localparam logic [2:0] CMD_CARVE = 3'd2;
    localparam logic [2:0] CMD_BUMP  = 3'd3;
    localparam logic [2:0] CMD_READ  = 3'd4;

    // Status codes.
    localparam logic [1:0] STS_OK     = 2'd0;
    localparam logic [1:0] STS_FULL   = 2'd1;
    localparam logic [1:0] STS_INSIDE = 2'd2;
    localparam logic [1:0] STS_NOMEM  = 2'd3;

    // Configuration register indexes.
    localparam logic CFG_PAGE_SHIFT = 1'b0;
    localparam logic CFG_LOW_FLOOR  = 1'b1;

    typedef struct packed {
        logic [31:0] rtype;
        logic [63:0] len;
        logic [63:0] base;
    } entry_t;

    typedef enum logic [5:0] {
        OP_NONE, OP_LOAD, OP_ADD, OP_RD_ISSUE, OP_RD_TAKE,
        OP_B_INIT, OP_B_DIV, OP_B_ALIGN, OP_B_COMMIT, OP_C_INIT,
        OP_SC_RD, OP_SC_SUM, OP_SC_CHK, OP_C_CUT, OP_C_APP1, OP_C_APP2,
        OP_DR_RD, OP_DR_WR, OP_SA_I, OP_SA_TI, OP_SA_J, OP_SA_J1, OP_SA_J2,
        OP_FIT1, OP_FIT2, OP_FIT3, OP_FIT4,
        OP_SO_P, OP_SO_M0, OP_SO_K, OP_SO_K1, OP_SO_SW1, OP_SO_SW2, OP_OUT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } mrme_cmd_t;

    typedef struct packed {
        logic [2:0] cmd;
        logic       i_lt_cnt;
        logic       j_lt_cnt;
        logic       j1_lt_cnt;
        logic       j_eq_i;
        logic       p_more;
        logic       div_last;
        logic       b_wrap1;
        logic       b_wrap2;
        logic       c_wrap;
        logic       match;
        logic       cut_zero;
        logic       full;
        logic       rd_usable;
        logic       trim_err;
        logic       keep;
        logic       out_free;
    } mrme_sts_t;

endpackage

// ----- hw/rtl/mrme_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrme_dp
// Datapath: region table memory, working registers, remainder unit and the
// result register, driven one operation per cycle by the controller.
// ----------------------------------------------------------------------------
module mrme_dp
    import mrme_pkg::*;
#(
    parameter int MAX_REGIONS = MRME_MAX_REGIONS
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic                 cfg_addr,
    input  logic [31:0]          cfg_wr_data,
    input  logic [S_TDATA_W-1:0] s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,
    input  mrme_cmd_t            cmd,
    output mrme_sts_t            sts
);

    localparam int IDX_W = $clog2(MAX_REGIONS);
    localparam int CNT_W = $clog2(MAX_REGIONS + 1);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_REGIONS);

    entry_t mem [MAX_REGIONS];

    logic [IDX_W-1:0] rd_addr, wr_addr;
    logic             mem_we;
    entry_t           wr_data;
    entry_t           rdata_reg;

    logic [4:0]  ps_reg;
    logic [31:0] floor_reg;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [63:0] bump_reg, bump_next;

    logic [2:0]  cmd_reg, cmd_next;
    logic [63:0] b_in_reg, b_in_next, l_in_reg, l_in_next;
    logic [31:0] t_in_reg, t_in_next;
    logic [30:0] al_in_reg, al_in_next;
    logic [7:0]  idx_reg, idx_next;

    logic [CNT_W-1:0] i_reg, i_next, j_reg, j_next, m_reg, m_next;
    logic [63:0] sb_reg, sb_next, st_reg, st_next;
    logic [63:0] rb_reg, rb_next, rt_reg, rt_next;
    logic        usable_reg, usable_next;
    logic [63:0] cb_reg, cb_next, ct_reg, ct_next;
    logic [63:0] fl_len_reg, fl_len_next, ftop_reg, ftop_next;
    logic        fcarry_reg, fcarry_next, fok_reg, fok_next;
    entry_t      min_reg, min_next;

    logic [63:0] up_reg, up_next, dq_reg, dq_next;
    logic [30:0] rem_reg, rem_next, alf_reg, alf_next;
    logic [5:0]  dcnt_reg, dcnt_next;

    logic [1:0]  res_st_reg, res_st_next;
    logic [63:0] res_b_reg, res_b_next, res_l_reg, res_l_next;
    logic [31:0] res_t_reg, res_t_next;

    logic        m_tvalid_reg, m_tvalid_next;
    logic [170:0] m_data_reg, m_data_next;

    // Combinational helpers.
    logic [63:0] ps, pm1, mask, floor64;
    logic [30:0] al0;
    logic [64:0] b_sum, c_sum, nb_sum;
    logic [31:0] shl;
    logic [63:0] upa, topa, cutl, tail, rt_j, tn, keep_len, keep_base;
    logic        bin, tin, keep, fit_low;
    logic [CNT_W:0] j1, i1;

    assign ps      = 64'd1 << ps_reg;
    assign pm1     = ps - 64'd1;
    assign mask    = ~pm1;
    assign floor64 = {32'd0, floor_reg};
    assign al0     = (al_in_reg == 31'd0) ? 31'd1 : al_in_reg;
    assign b_sum   = {1'b0, bump_reg} + {34'd0, al0 - 31'd1};
    assign c_sum   = {1'b0, b_in_reg} + {1'b0, l_in_reg};
    assign nb_sum  = {1'b0, cb_reg} + {1'b0, pm1};
    assign shl     = {rem_reg, dq_reg[63]};
    assign upa     = up_reg - {33'd0, rem_reg};
    assign topa    = upa + l_in_reg;
    assign cutl    = sb_reg - rb_reg;
    assign tail    = rt_reg - st_reg;
    assign rt_j    = rdata_reg.base + rdata_reg.len;
    assign j1      = {1'b0, j_reg} + {{CNT_W{1'b0}}, 1'b1};
    assign i1      = {1'b0, i_reg} + {{CNT_W{1'b0}}, 1'b1};

    assign bin = (rb_reg >= cb_reg) && (rb_reg < ct_reg);
    assign tin = (rt_reg >= cb_reg) && (rt_reg < ct_reg);
    assign tn  = bin ? rb_reg : ct_reg;

    // Final step of page fitting: clip at the floor.
    assign fit_low = cb_reg < floor64;
    always_comb begin
        keep      = fok_reg;
        keep_len  = fl_len_reg;
        keep_base = cb_reg;
        if (fit_low) begin
            if (ftop_reg > floor64) begin
                keep_len  = fl_len_reg - (floor64 - cb_reg);
                keep_base = floor64;
            end else begin
                keep = 1'b0;
            end
        end
    end

    always_comb begin
        sts.cmd       = cmd_reg;
        sts.i_lt_cnt  = i_reg < cnt_reg;
        sts.j_lt_cnt  = j_reg < cnt_reg;
        sts.j1_lt_cnt = j1 < {1'b0, cnt_reg};
        sts.j_eq_i    = j_reg == i_reg;
        sts.p_more    = i1 < {1'b0, cnt_reg};
        sts.div_last  = dcnt_reg == 6'd63;
        sts.b_wrap1   = b_sum[64];
        sts.b_wrap2   = topa < upa;
        sts.c_wrap    = c_sum[64];
        sts.match     = usable_reg && (sb_reg >= rb_reg) && (sb_reg < rt_reg)
                        && (st_reg >= rb_reg) && (st_reg < rt_reg);
        sts.cut_zero  = cutl == 64'd0;
        sts.full      = cnt_reg >= MAX_CNT;
        sts.rd_usable = rdata_reg.rtype == USABLE_TYPE;
        sts.trim_err  = bin && tin;
        sts.keep      = keep;
        sts.out_free  = !m_tvalid_reg || m_tready;
    end

    always_comb begin
        cnt_next = cnt_reg;        bump_next = bump_reg;
        cmd_next = cmd_reg;        b_in_next = b_in_reg;
        l_in_next = l_in_reg;      t_in_next = t_in_reg;
        al_in_next = al_in_reg;    idx_next = idx_reg;
        i_next = i_reg;            j_next = j_reg;            m_next = m_reg;
        sb_next = sb_reg;          st_next = st_reg;
        rb_next = rb_reg;          rt_next = rt_reg;          usable_next = usable_reg;
        cb_next = cb_reg;          ct_next = ct_reg;
        fl_len_next = fl_len_reg;  ftop_next = ftop_reg;
        fcarry_next = fcarry_reg;  fok_next = fok_reg;        min_next = min_reg;
        up_next = up_reg;          dq_next = dq_reg;
        rem_next = rem_reg;        alf_next = alf_reg;        dcnt_next = dcnt_reg;
        res_st_next = res_st_reg;  res_b_next = res_b_reg;
        res_l_next = res_l_reg;    res_t_next = res_t_reg;
        m_data_next = m_data_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        rd_addr = '0;
        wr_addr = '0;
        mem_we  = 1'b0;
        wr_data = '0;

        unique case (cmd.op)
            OP_LOAD: begin
                cmd_next    = s_tdata[2:0];
                b_in_next   = s_tdata[66:3];
                l_in_next   = s_tdata[130:67];
                t_in_next   = s_tdata[162:131];
                al_in_next  = s_tdata[193:163];
                idx_next    = s_tdata[201:194];
                i_next      = '0;
                res_st_next = STS_OK;
                res_b_next  = '0;
                res_l_next  = '0;
                res_t_next  = '0;
            end
            OP_ADD: begin
                if (sts.full) begin
                    res_st_next = STS_FULL;
                end else begin
                    mem_we   = 1'b1;
                    wr_addr  = cnt_reg[IDX_W-1:0];
                    wr_data  = '{rtype: t_in_reg, len: l_in_reg, base: b_in_reg};
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            OP_RD_ISSUE: rd_addr = IDX_W'(idx_reg);
            OP_RD_TAKE: begin
                if (32'(idx_reg) < 32'(cnt_reg)) begin
                    res_b_next = rdata_reg.base;
                    res_l_next = rdata_reg.len;
                    res_t_next = rdata_reg.rtype;
                end
            end
            OP_B_INIT: begin
                if (b_sum[64]) begin
                    res_st_next = STS_NOMEM;
                end else begin
                    up_next   = b_sum[63:0];
                    dq_next   = b_sum[63:0];
                    rem_next  = '0;
                    alf_next  = al0;
                    dcnt_next = '0;
                end
            end
            OP_B_DIV: begin
                // One quotient bit a cycle; only the remainder is kept.
                if (shl >= {1'b0, alf_reg}) begin
                    rem_next = 31'(shl - {1'b0, alf_reg});
                end else begin
                    rem_next = shl[30:0];
                end
                dq_next   = {dq_reg[62:0], 1'b0};
                dcnt_next = dcnt_reg + 6'd1;
            end
            OP_B_ALIGN: begin
                if (topa < upa) begin
                    res_st_next = STS_NOMEM;
                end else begin
                    sb_next = upa;
                    st_next = topa;
                end
            end
            OP_B_COMMIT: begin
                bump_next  = st_reg;
                res_b_next = sb_reg;
            end
            OP_C_INIT: begin
                if (c_sum[64]) begin
                    res_st_next = STS_NOMEM;
                end else begin
                    sb_next = b_in_reg;
                    st_next = c_sum[63:0];
                end
            end
            OP_SC_RD: begin
                if (sts.i_lt_cnt) begin
                    rd_addr = i_reg[IDX_W-1:0];
                end else begin
                    res_st_next = STS_NOMEM;
                end
            end
            OP_SC_SUM: begin
                rb_next     = rdata_reg.base;
                rt_next     = rt_j;
                usable_next = rdata_reg.rtype == USABLE_TYPE;
            end
            OP_SC_CHK: begin
                if (!sts.match) begin
                    i_next = i_reg + 1'b1;
                end
            end
            OP_C_CUT: begin
                if (cutl == 64'd0) begin
                    j_next = i_reg;
                end else begin
                    mem_we  = 1'b1;
                    wr_addr = i_reg[IDX_W-1:0];
                    wr_data = '{rtype: USABLE_TYPE, len: cutl, base: rb_reg};
                end
            end
            OP_C_APP1: begin
                if (sts.full) begin
                    res_st_next = STS_FULL;
                end else if (tail != 64'd0) begin
                    mem_we   = 1'b1;
                    wr_addr  = cnt_reg[IDX_W-1:0];
                    wr_data  = '{rtype: USABLE_TYPE, len: tail, base: st_reg};
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            OP_C_APP2: begin
                if (sts.full) begin
                    res_st_next = STS_FULL;
                end else begin
                    mem_we   = 1'b1;
                    wr_addr  = cnt_reg[IDX_W-1:0];
                    wr_data  = '{rtype: t_in_reg, len: l_in_reg, base: b_in_reg};
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            OP_DR_RD: begin
                if (sts.j1_lt_cnt) begin
                    rd_addr = j1[IDX_W-1:0];
                end else begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            OP_DR_WR: begin
                mem_we  = 1'b1;
                wr_addr = j_reg[IDX_W-1:0];
                wr_data = rdata_reg;
                j_next  = j_reg + 1'b1;
            end
            OP_SA_I: begin
                if (sts.i_lt_cnt) begin
                    rd_addr = i_reg[IDX_W-1:0];
                end else begin
                    i_next = '0;
                end
            end
            OP_SA_TI: begin
                if (sts.rd_usable) begin
                    cb_next = rdata_reg.base;
                    ct_next = rt_j;
                    j_next  = '0;
                end else begin
                    i_next = i_reg + 1'b1;
                end
            end
            OP_SA_J: begin
                if (sts.j_eq_i) begin
                    j_next = j_reg + 1'b1;
                end else begin
                    rd_addr = j_reg[IDX_W-1:0];
                end
            end
            OP_SA_J1: begin
                rb_next = rdata_reg.base;
                rt_next = rt_j;
                j_next  = j_reg + 1'b1;
            end
            OP_SA_J2: begin
                if (bin && tin) begin
                    // The trimmed state so far is kept in the table.
                    mem_we      = 1'b1;
                    wr_addr     = i_reg[IDX_W-1:0];
                    wr_data     = '{rtype: USABLE_TYPE, len: ct_reg - cb_reg, base: cb_reg};
                    res_st_next = STS_INSIDE;
                end else begin
                    if ((rt_reg >= cb_reg) && (rt_reg < tn)) begin
                        cb_next = rt_reg;
                    end
                    ct_next = tn;
                end
            end
            OP_FIT1: begin
                fl_len_next = ct_reg - cb_reg;
                fcarry_next = nb_sum[64];
                ftop_next   = nb_sum[63:0] & mask;
            end
            OP_FIT2: begin
                fok_next    = (fl_len_reg >= ps) && !fcarry_reg;
                fl_len_next = (fl_len_reg - (ftop_reg - cb_reg)) & mask;
                cb_next     = ftop_reg;
            end
            OP_FIT3: begin
                fok_next  = fok_reg && (fl_len_reg != 64'd0);
                ftop_next = cb_reg + fl_len_reg;
            end
            OP_FIT4: begin
                if (keep) begin
                    mem_we  = 1'b1;
                    wr_addr = i_reg[IDX_W-1:0];
                    wr_data = '{rtype: USABLE_TYPE, len: keep_len, base: keep_base};
                    i_next  = i_reg + 1'b1;
                end else begin
                    j_next = i_reg;
                end
            end
            OP_SO_P: begin
                if (sts.p_more) begin
                    rd_addr = i_reg[IDX_W-1:0];
                    j_next  = i1[CNT_W-1:0];
                    m_next  = i_reg;
                end
            end
            OP_SO_M0: min_next = rdata_reg;
            OP_SO_K: begin
                if (sts.j_lt_cnt) begin
                    rd_addr = j_reg[IDX_W-1:0];
                end else begin
                    rd_addr = i_reg[IDX_W-1:0];
                end
            end
            OP_SO_K1: begin
                if (rdata_reg.base < min_reg.base) begin
                    min_next = rdata_reg;
                    m_next   = j_reg;
                end
                j_next = j_reg + 1'b1;
            end
            OP_SO_SW1: begin
                mem_we  = 1'b1;
                wr_addr = m_reg[IDX_W-1:0];
                wr_data = rdata_reg;
            end
            OP_SO_SW2: begin
                mem_we  = 1'b1;
                wr_addr = i_reg[IDX_W-1:0];
                wr_data = min_reg;
                i_next  = i_reg + 1'b1;
            end
            OP_OUT: begin
                if (sts.out_free) begin
                    m_tvalid_next = 1'b1;
                    m_data_next   = {9'(cnt_reg), res_t_reg, res_l_reg, res_b_reg,
                                     res_st_reg};
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[wr_addr] <= wr_data;
        end
        rdata_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ps_reg       <= PAGE_SHIFT_RESET;
            floor_reg    <= LOW_FLOOR_RESET;
            cnt_reg      <= '0;
            bump_reg     <= BUMP_RESET;
            m_tvalid_reg <= 1'b0;
            rem_reg      <= '0;
            alf_reg      <= 31'd1;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_addr)
                    CFG_PAGE_SHIFT: ps_reg    <= cfg_wr_data[4:0];
                    CFG_LOW_FLOOR:  floor_reg <= cfg_wr_data;
                    default: ;
                endcase
            end
            cnt_reg      <= cnt_next;
            bump_reg     <= bump_next;
            m_tvalid_reg <= m_tvalid_next;
            rem_reg      <= rem_next;
            alf_reg      <= alf_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg <= cmd_next;       b_in_reg <= b_in_next;
        l_in_reg <= l_in_next;     t_in_reg <= t_in_next;
        al_in_reg <= al_in_next;   idx_reg <= idx_next;
        i_reg <= i_next;           j_reg <= j_next;           m_reg <= m_next;
        sb_reg <= sb_next;         st_reg <= st_next;
        rb_reg <= rb_next;         rt_reg <= rt_next;         usable_reg <= usable_next;
        cb_reg <= cb_next;         ct_reg <= ct_next;
        fl_len_reg <= fl_len_next; ftop_reg <= ftop_next;
        fcarry_reg <= fcarry_next; fok_reg <= fok_next;       min_reg <= min_next;
        up_reg <= up_next;         dq_reg <= dq_next;         dcnt_reg <= dcnt_next;
        res_st_reg <= res_st_next; res_b_reg <= res_b_next;
        res_l_reg <= res_l_next;   res_t_reg <= res_t_next;
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {5'd0, m_data_reg};

`ifndef ASSERT_OFF
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= MAX_CNT)
        else $error("region count above table size");

    a_rem_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        rem_reg < alf_reg)
        else $error("alignment remainder not below divisor");

    a_cnt_step: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg != $past(cnt_reg) |->
            (cnt_reg == $past(cnt_reg) + 1'b1 || cnt_reg == $past(cnt_reg) - 1'b1))
        else $error("region count moved by more than one");
`endif

endmodule

// ----- hw/rtl/mrme_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrme_ctrl
// Controller: sequences the datapath through each command.
// ----------------------------------------------------------------------------
module mrme_ctrl
    import mrme_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  mrme_sts_t sts,
    output mrme_cmd_t cmd
);

    localparam int NST = 34;

    typedef enum logic [NST-1:0] {
        ST_IDLE    = NST'(1) << 0,  ST_DISP    = NST'(1) << 1,
        ST_ADD     = NST'(1) << 2,  ST_RD0     = NST'(1) << 3,
        ST_RD1     = NST'(1) << 4,  ST_BINIT   = NST'(1) << 5,
        ST_BDIV    = NST'(1) << 6,  ST_BALIGN  = NST'(1) << 7,
        ST_CINIT   = NST'(1) << 8,  ST_SC_RD   = NST'(1) << 9,
        ST_SC_SUM  = NST'(1) << 10, ST_SC_CHK  = NST'(1) << 11,
        ST_BCOMMIT = NST'(1) << 12, ST_CCUT    = NST'(1) << 13,
        ST_CAPP1   = NST'(1) << 14, ST_CAPP2   = NST'(1) << 15,
        ST_DR_RD   = NST'(1) << 16, ST_DR_WR   = NST'(1) << 17,
        ST_SA_I    = NST'(1) << 18, ST_SA_TI   = NST'(1) << 19,
        ST_SA_J    = NST'(1) << 20, ST_SA_J1   = NST'(1) << 21,
        ST_SA_J2   = NST'(1) << 22, ST_FIT1    = NST'(1) << 23,
        ST_FIT2    = NST'(1) << 24, ST_FIT3    = NST'(1) << 25,
        ST_FIT4    = NST'(1) << 26, ST_SO_P    = NST'(1) << 27,
        ST_SO_M0   = NST'(1) << 28, ST_SO_K    = NST'(1) << 29,
        ST_SO_K1   = NST'(1) << 30, ST_SO_SW1  = NST'(1) << 31,
        ST_SO_SW2  = NST'(1) << 32, ST_DONE    = NST'(1) << 33
    } state_t;

    state_t state_reg, state_next;

    assign s_tready = state_reg == ST_IDLE;

    always_comb begin
        state_next = state_reg;
        cmd.op     = OP_NONE;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.op     = OP_LOAD;
                    state_next = ST_DISP;
                end
            end
            ST_DISP: begin
                unique case (sts.cmd)
                    CMD_ADD:   state_next = ST_ADD;
                    CMD_SAN:   state_next = ST_SA_I;
                    CMD_CARVE: state_next = ST_CINIT;
                    CMD_BUMP:  state_next = ST_BINIT;
                    CMD_READ:  state_next = ST_RD0;
                    default:   state_next = ST_DONE;
                endcase
            end
            ST_ADD: begin
                cmd.op = OP_ADD;
                state_next = ST_DONE;
            end
            ST_RD0: begin
                cmd.op = OP_RD_ISSUE;
                state_next = ST_RD1;
            end
            ST_RD1: begin
                cmd.op = OP_RD_TAKE;
                state_next = ST_DONE;
            end
            ST_BINIT: begin
                cmd.op = OP_B_INIT;
                state_next = sts.b_wrap1 ? ST_DONE : ST_BDIV;
            end
            ST_BDIV: begin
                cmd.op = OP_B_DIV;
                if (sts.div_last) begin
                    state_next = ST_BALIGN;
                end
            end
            ST_BALIGN: begin
                cmd.op = OP_B_ALIGN;
                state_next = sts.b_wrap2 ? ST_DONE : ST_SC_RD;
            end
            ST_CINIT: begin
                cmd.op = OP_C_INIT;
                state_next = sts.c_wrap ? ST_DONE : ST_SC_RD;
            end
            ST_SC_RD: begin
                cmd.op = OP_SC_RD;
                state_next = sts.i_lt_cnt ? ST_SC_SUM : ST_DONE;
            end
            ST_SC_SUM: begin
                cmd.op = OP_SC_SUM;
                state_next = ST_SC_CHK;
            end
            ST_SC_CHK: begin
                cmd.op = OP_SC_CHK;
                if (!sts.match) begin
                    state_next = ST_SC_RD;
                end else if (sts.cmd == CMD_BUMP) begin
                    state_next = ST_BCOMMIT;
                end else begin
                    state_next = ST_CCUT;
                end
            end
            ST_BCOMMIT: begin
                cmd.op = OP_B_COMMIT;
                state_next = ST_DONE;
            end
            ST_CCUT: begin
                cmd.op = OP_C_CUT;
                state_next = sts.cut_zero ? ST_DR_RD : ST_CAPP1;
            end
            ST_CAPP1: begin
                cmd.op = OP_C_APP1;
                state_next = sts.full ? ST_DONE : ST_CAPP2;
            end
            ST_CAPP2: begin
                cmd.op = OP_C_APP2;
                state_next = ST_DONE;
            end
            ST_DR_RD: begin
                cmd.op = OP_DR_RD;
                if (sts.j1_lt_cnt) begin
                    state_next = ST_DR_WR;
                end else if (sts.cmd == CMD_CARVE) begin
                    state_next = ST_CAPP1;
                end else begin
                    state_next = ST_SA_I;
                end
            end
            ST_DR_WR: begin
                cmd.op = OP_DR_WR;
                state_next = ST_DR_RD;
            end
            ST_SA_I: begin
                cmd.op = OP_SA_I;
                state_next = sts.i_lt_cnt ? ST_SA_TI : ST_SO_P;
            end
            ST_SA_TI: begin
                cmd.op = OP_SA_TI;
                state_next = sts.rd_usable ? ST_SA_J : ST_SA_I;
            end
            ST_SA_J: begin
                cmd.op = OP_SA_J;
                if (!sts.j_lt_cnt) begin
                    cmd.op     = OP_NONE;
                    state_next = ST_FIT1;
                end else if (!sts.j_eq_i) begin
                    state_next = ST_SA_J1;
                end
            end
            ST_SA_J1: begin
                cmd.op = OP_SA_J1;
                state_next = ST_SA_J2;
            end
            ST_SA_J2: begin
                cmd.op = OP_SA_J2;
                state_next = sts.trim_err ? ST_DONE : ST_SA_J;
            end
            ST_FIT1: begin
                cmd.op = OP_FIT1;
                state_next = ST_FIT2;
            end
            ST_FIT2: begin
                cmd.op = OP_FIT2;
                state_next = ST_FIT3;
            end
            ST_FIT3: begin
                cmd.op = OP_FIT3;
                state_next = ST_FIT4;
            end
            ST_FIT4: begin
                cmd.op = OP_FIT4;
                state_next = sts.keep ? ST_SA_I : ST_DR_RD;
            end
            ST_SO_P: begin
                cmd.op = OP_SO_P;
                state_next = sts.p_more ? ST_SO_M0 : ST_DONE;
            end
            ST_SO_M0: begin
                cmd.op = OP_SO_M0;
                state_next = ST_SO_K;
            end
            ST_SO_K: begin
                cmd.op = OP_SO_K;
                state_next = sts.j_lt_cnt ? ST_SO_K1 : ST_SO_SW1;
            end
            ST_SO_K1: begin
                cmd.op = OP_SO_K1;
                state_next = ST_SO_K;
            end
            ST_SO_SW1: begin
                cmd.op = OP_SO_SW1;
                state_next = ST_SO_SW2;
            end
            ST_SO_SW2: begin
                cmd.op = OP_SO_SW2;
                state_next = ST_SO_P;
            end
            ST_DONE: begin
                cmd.op = OP_OUT;
                if (sts.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- hw/rtl/memory_region_map_engine_unit.sv -----
`timescale 1ns / 1ps
// One item is in work at a time; the remainder unit and the table scan set
// the time per item. A result waiting in the output register does not stop
// the next item being accepted.
// Synchronous active-low reset empties the table and restores the registers.
// ----------------------------------------------------------------------------
// memory_region_map_engine_unit
// Region table engine: add, sanitise, carve, bump allocate and read commands.
// ----------------------------------------------------------------------------
module memory_region_map_engine_unit
    import mrme_pkg::*;
#(
    parameter int MAX_REGIONS = MRME_MAX_REGIONS
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic                 cfg_addr,
    input  logic [31:0]          cfg_wr_data,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // command, base, length, region_type, alignment, entry_index
    input  logic [S_TDATA_W-1:0] s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // status, result_base, result_length, result_type, entry_count
    output logic [M_TDATA_W-1:0] m_tdata
);

    mrme_cmd_t cmd;
    mrme_sts_t sts;

    mrme_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    mrme_dp #(
        .MAX_REGIONS (MAX_REGIONS)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cmd         (cmd),
        .sts         (sts)
    );

endmodule

// ----- tb/memory_region_map_engine_unit_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// memory_region_map_engine_unit_test
// Self-checking bench for the region table engine. A behavioural copy of the
// table, the bump pointer and both registers predicts one result per command.
// Directed cases cover the corner behaviour, then random command
// streams run under several register settings with random stalls on both
// sides. The last phase fills the table to the brim.
// ----------------------------------------------------------------------------
module memory_region_map_engine_unit_test;
    import mrme_pkg::*;

    typedef struct {
        logic [2:0]  cmd;
        logic [63:0] base;
        logic [63:0] len;
        logic [31:0] rtype;
        logic [30:0] align;
        logic [7:0]  idx;
    } map_cmd_t;

    typedef struct {
        logic [1:0]  status;
        logic [63:0] rbase;
        logic [63:0] rlen;
        logic [31:0] rtype;
        logic [8:0]  count;
    } map_result_t;

    localparam int REGION_CAP = 60;
    localparam int FOREIGN_CAP = 20;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic                 cfg_addr = 1'b0;
    logic [31:0]          cfg_wr_data = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    // Shadow copy of the block's state.
    logic [63:0] tbl_base [MRME_MAX_REGIONS];
    logic [63:0] tbl_len  [MRME_MAX_REGIONS];
    logic [31:0] tbl_type [MRME_MAX_REGIONS];
    int unsigned region_count;
    logic [63:0] bump_ptr;
    logic [4:0]  cfg_shift;
    logic [31:0] cfg_floor;

    map_result_t pending_results[$];
    int          mismatches = 0;
    int          errors = 0;
    bit          idle_on = 1'b1;
    int          rx_hold = 0;

    memory_region_map_engine_unit DUT (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wr_data(cfg_wr_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    initial begin
        #20_000_000;
        $display("memory_region_map_engine_unit_test NOT OK");
        $finish;
    end

    // ---------------------------------------------------------------- model
    function automatic void drop_slot(int unsigned k);
        for (int unsigned j = k; j + 1 < region_count; j++) begin
            tbl_base[j] = tbl_base[j+1];
            tbl_len[j]  = tbl_len[j+1];
            tbl_type[j] = tbl_type[j+1];
        end
        region_count--;
    endfunction

    function automatic void append_slot(logic [63:0] b, logic [63:0] l, logic [31:0] t);
        tbl_base[region_count] = b;
        tbl_len[region_count]  = l;
        tbl_type[region_count] = t;
        region_count++;
    endfunction

    function automatic bit page_fit(inout logic [63:0] b, inout logic [63:0] l);
        logic [63:0] ps, mask, nb, top, fl;
        ps = 64'd1 << cfg_shift;
        mask = ~(ps - 64'd1);
        fl = {32'd0, cfg_floor};
        if (l < ps) return 1'b0;
        nb = (b + (ps - 64'd1)) & mask;
        if (nb < b) return 1'b0;
        l = (l - (nb - b)) & mask;
        b = nb;
        if (l == 64'd0) return 1'b0;
        top = nb + l;
        if (nb < fl) begin
            if (top > fl) begin
                l = l - (fl - nb);
                b = fl;
            end else begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    function automatic logic [1:0] sanitise_table();
        int unsigned i, m;
        logic [63:0] b, t, rb, rt, tb, tl;
        logic [31:0] tt;
        bit bin, tin, ok;
        i = 0;
        while (i < region_count) begin
            if (tbl_type[i] != USABLE_TYPE) begin
                i++;
                continue;
            end
            for (int unsigned j = 0; j < region_count; j++) begin
                if (j == i) continue;
                b = tbl_base[i];
                t = b + tbl_len[i];
                rb = tbl_base[j];
                rt = rb + tbl_len[j];
                bin = rb >= b && rb < t;
                tin = rt >= b && rt < t;
                if (bin && tin) return STS_INSIDE;
                if (bin) t = rb;
                if (rt >= b && rt < t) b = rt;
                tbl_base[i] = b;
                tbl_len[i] = t - b;
            end
            if (tbl_len[i] == 64'd0) begin
                drop_slot(i);
            end else begin
                b = tbl_base[i];
                t = tbl_len[i];
                ok = page_fit(b, t);
                tbl_base[i] = b;
                tbl_len[i] = t;
                if (ok) i++;
                else drop_slot(i);
            end
        end
        if (region_count > 1) begin
            for (int unsigned p = 0; p + 1 < region_count; p++) begin
                m = p;
                for (int unsigned k = p; k < region_count; k++)
                    if (tbl_base[k] < tbl_base[m]) m = k;
                tb = tbl_base[m]; tl = tbl_len[m]; tt = tbl_type[m];
                tbl_base[m] = tbl_base[p]; tbl_len[m] = tbl_len[p];
                tbl_type[m] = tbl_type[p];
                tbl_base[p] = tb; tbl_len[p] = tl; tbl_type[p] = tt;
            end
        end
        return STS_OK;
    endfunction

    function automatic int find_usable(logic [63:0] b, logic [63:0] t);
        logic [63:0] eb, et;
        for (int unsigned i = 0; i < region_count; i++) begin
            if (tbl_type[i] != USABLE_TYPE) continue;
            eb = tbl_base[i];
            et = eb + tbl_len[i];
            if (b >= eb && b < et && t >= eb && t < et) return i;
        end
        return -1;
    endfunction

    function automatic logic [1:0] carve_range(logic [63:0] b, logic [63:0] l,
                                               logic [31:0] t);
        logic [63:0] top, eb, et;
        int f;
        top = b + l;
        if (top < b) return STS_NOMEM;
        f = find_usable(b, top);
        if (f < 0) return STS_NOMEM;
        eb = tbl_base[f];
        et = eb + tbl_len[f];
        tbl_len[f] = b - eb;
        if (tbl_len[f] == 64'd0) drop_slot(f);
        if (region_count >= MRME_MAX_REGIONS) return STS_FULL;
        if (et - top != 64'd0) append_slot(top, et - top, USABLE_TYPE);
        if (region_count >= MRME_MAX_REGIONS) return STS_FULL;
        append_slot(b, l, t);
        return STS_OK;
    endfunction

    function automatic map_result_t map_step(map_cmd_t c);
        map_result_t r;
        logic [63:0] al, up, top;
        r = '{default: '0};
        case (c.cmd)
            CMD_ADD: begin
                if (region_count >= MRME_MAX_REGIONS) r.status = STS_FULL;
                else append_slot(c.base, c.len, c.rtype);
            end
            CMD_SAN: r.status = sanitise_table();
            CMD_CARVE: r.status = carve_range(c.base, c.len, c.rtype);
            CMD_BUMP: begin
                al = {33'd0, c.align};
                if (al == 64'd0) al = 64'd1;
                up = bump_ptr + (al - 64'd1);
                if (up < bump_ptr) begin
                    r.status = STS_NOMEM;
                end else begin
                    up = up - (up % al);
                    top = up + c.len;
                    if (top < up || find_usable(up, top) < 0) begin
                        r.status = STS_NOMEM;
                    end else begin
                        bump_ptr = top;
                        r.rbase = up;
                    end
                end
            end
            CMD_READ: begin
                if (c.idx < region_count) begin
                    r.rbase = tbl_base[c.idx];
                    r.rlen  = tbl_len[c.idx];
                    r.rtype = tbl_type[c.idx];
                end
            end
            default: ;
        endcase
        r.count = region_count[8:0];
        return r;
    endfunction

    // ---------------------------------------------------------------- stalls
    function automatic int random_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!idle_on || r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    initial begin
        int stall;
        stall = 0;
        forever begin
            @(posedge aclk);
            if (rx_hold > 0) begin
                m_tready <= 1'b0;
                rx_hold--;
            end else if (stall > 0) begin
                m_tready <= 1'b0;
                stall--;
            end else if ($urandom_range(0, 9) < 7) begin
                m_tready <= 1'b1;
            end else begin
                stall = random_gap();
                m_tready <= (stall == 0);
            end
        end
    end

    // --------------------------------------------------------------- checker
    always @(posedge aclk) begin
        map_result_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got.status = m_tdata[1:0];
            got.rbase  = m_tdata[65:2];
            got.rlen   = m_tdata[129:66];
            got.rtype  = m_tdata[161:130];
            got.count  = m_tdata[170:162];
            if (pending_results.size() == 0) begin
                errors++;
                $display("Result arrived with nothing expected: %p", got);
            end else begin
                want = pending_results.pop_front();
                if (got.status !== want.status || got.rbase !== want.rbase ||
                    got.rlen !== want.rlen || got.rtype !== want.rtype ||
                    got.count !== want.count) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Mismatch: expected %p, got %p", want, got);
                end
            end
        end
    end

    // -------------------------------------------------------------- drivers
    task automatic send_command(map_cmd_t c);
        int n;
        s_tdata  <= {6'd0, c.idx, c.align, c.rtype, c.len, c.base, c.cmd};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        pending_results.push_back(map_step(c));
        n = random_gap();
        if (n > 0) begin
            s_tvalid <= 1'b0;
            repeat (n) @(posedge aclk);
        end
    endtask

    task automatic wait_results();
        int guard;
        guard = 0;
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0 && guard < 2_000_000) begin
            @(posedge aclk);
            guard++;
        end
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_register(logic addr, logic [31:0] value);
        wait_results();
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= addr;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (addr == CFG_PAGE_SHIFT) cfg_shift = value[4:0];
        else cfg_floor = value;
    endtask

    function automatic map_cmd_t make_cmd(logic [2:0] cmd, logic [63:0] b,
                                          logic [63:0] l, logic [31:0] t,
                                          logic [30:0] al, logic [7:0] idx);
        map_cmd_t c;
        c.cmd = cmd; c.base = b; c.len = l; c.rtype = t; c.align = al; c.idx = idx;
        return c;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // A new region must not sit wholly inside a usable one, and a new usable
    // region must not wrap any other, otherwise every later sanitise stops with the same error.
    function automatic bit nesting_free(logic [63:0] b, logic [63:0] l, logic [31:0] t);
        logic [63:0] top, eb, et;
        top = b + l;
        for (int unsigned i = 0; i < region_count; i++) begin
            eb = tbl_base[i];
            et = eb + tbl_len[i];
            if (tbl_type[i] == USABLE_TYPE && b >= eb && b < et && top >= eb && top < et)
                return 1'b0;
            if (t == USABLE_TYPE && eb >= b && eb < top && et >= b && et < top)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic int foreign_count();
        int n;
        n = 0;
        for (int unsigned i = 0; i < region_count; i++)
            if (tbl_type[i] != USABLE_TYPE) n++;
        return n;
    endfunction

    function automatic map_cmd_t random_command();
        map_cmd_t c;
        int r, pick, tries;
        logic [63:0] eb, el;
        c = make_cmd(3'(rand64()), rand64(), rand64(), $urandom, 31'($urandom),
                     8'($urandom));
        r = $urandom_range(0, 99);
        if (r < 26) begin
            c.cmd = CMD_ADD;
            c.base = ({60'd0, 4'($urandom)} << 28) + 64'($urandom & 32'h0FFF_FFFF);
            c.len = 64'($urandom_range(0, 32'h0800_0000));
            if ($urandom_range(0, 5) == 0 && foreign_count() < FOREIGN_CAP)
                c.rtype = $urandom;
            else
                c.rtype = USABLE_TYPE;
        end else if (r < 46) begin
            c.cmd = CMD_CARVE;
            pick = -1;
            for (tries = 0; tries < 8 && region_count > 0; tries++) begin
                pick = $urandom_range(0, region_count - 1);
                if (tbl_type[pick] == USABLE_TYPE) break;
                pick = -1;
            end
            if (pick >= 0 && tbl_len[pick] > 64'd4) begin
                eb = tbl_base[pick];
                el = tbl_len[pick];
                c.base = eb + rand64() % (el >> 1);
                c.len = rand64() % (el >> 2);
            end
            c.rtype = ($urandom_range(0, 9) < 6 || foreign_count() >= FOREIGN_CAP)
                      ? USABLE_TYPE : $urandom;
        end else if (r < 70) begin
            c.cmd = CMD_BUMP;
            c.len = 64'($urandom_range(0, 32'h0001_0000));
            if ($urandom_range(0, 19) == 0) c.align = 31'($urandom);
            else if ($urandom_range(0, 19) == 0) c.align = '0;
            else c.align = 31'd1 << $urandom_range(0, 12);
        end else if (r < 90) begin
            c.cmd = CMD_READ;
            if ($urandom_range(0, 1) == 0) c.idx = 8'($urandom_range(0, region_count));
        end else if (r < 94) begin
            c.cmd = CMD_SAN;
        end
        // The rest is random noise; keep the table small and free of nesting.
        if ((c.cmd == CMD_ADD || c.cmd == CMD_CARVE) &&
            (region_count >= REGION_CAP || !nesting_free(c.base, c.len, c.rtype)))
            c.cmd = CMD_READ;
        if (c.cmd == CMD_SAN && region_count > 40 && $urandom_range(0, 3) != 0)
            c.cmd = CMD_READ;
        return c;
    endfunction

    // ---------------------------------------------------------------- tests
    task automatic test_empty_table();
        send_command(make_cmd(CMD_READ, '1, '1, '1, '1, 8'd0));
        send_command(make_cmd(CMD_READ, '0, '0, '0, '0, 8'hFF));
        send_command(make_cmd(3'd7, '1, '1, '1, '1, 8'hFF));
        send_command(make_cmd(CMD_BUMP, '0, 64'h100, '0, 31'd1, '0));
        send_command(make_cmd(CMD_SAN, '0, '0, '0, '0, '0));
    endtask

    task automatic test_directed_map();
        send_command(make_cmd(CMD_ADD, 64'h10_0000, 64'h1000_0000, USABLE_TYPE, '0, '0));
        send_command(make_cmd(CMD_ADD, 64'h2000_0000, 64'h1000, 32'hFFFF_FFFF, '0, '0));
        send_command(make_cmd(CMD_ADD, 64'hFFFF_FFFF_FFFF_F000, 64'h10, 32'd0, '0, '0));
        // Base cannot be rounded up to a page without wrapping.
        send_command(make_cmd(CMD_ADD, 64'hFFFF_FFFF_FFFF_F001, 64'hFFF,
                              USABLE_TYPE, '0, '0));
        // Wholly below the floor, and one straddling it.
        send_command(make_cmd(CMD_ADD, 64'h1000, 64'h2000, USABLE_TYPE, '0, '0));
        send_command(make_cmd(CMD_ADD, 64'h8_0000, 64'h10_0000, USABLE_TYPE, '0, '0));
        send_command(make_cmd(CMD_SAN, '0, '0, '0, '0, '0));
        for (int i = 0; i < 4; i++)
            send_command(make_cmd(CMD_READ, '0, '0, '0, '0, 8'(i)));
        send_command(make_cmd(CMD_BUMP, '0, 64'h100, '0, 31'd0, '0));
        send_command(make_cmd(CMD_BUMP, '0, 64'h20, '0, 31'h1000, '0));
        send_command(make_cmd(CMD_BUMP, '0, '1, '0, 31'd1, '0));
        send_command(make_cmd(CMD_BUMP, '0, 64'h10, '0, 31'h7FFF_FFFF, '0));
        send_command(make_cmd(CMD_CARVE, '1, 64'd2, 32'd7, '0, '0));
        send_command(make_cmd(CMD_CARVE, 64'h20_0000, 64'h1000, 32'd7, '0, '0));
        send_command(make_cmd(CMD_CARVE, 64'h5_0000_0000, 64'h10, 32'd7, '0, '0));
        send_command(make_cmd(CMD_READ, '0, '0, '0, '0, 8'hFF));
    endtask

    task automatic test_random_traffic(int items);
        for (int n = 0; n < items; n++) begin
            // Every so often a stretch with no idling on either side.
            if (n % 100 == 0) idle_on = ($urandom_range(0, 3) != 0);
            send_command(random_command());
        end
        idle_on = 1'b1;
    endtask

    task automatic test_output_backpressure();
        rx_hold = 400;
        idle_on = 1'b0;
        for (int n = 0; n < 12; n++)
            send_command(make_cmd(CMD_READ, '0, '0, '0, '0, 8'(n)));
        idle_on = 1'b1;
        wait_results();
    endtask

    task automatic test_full_table();
        wait_results();
        write_register(CFG_PAGE_SHIFT, 32'd12);
        write_register(CFG_LOW_FLOOR, 32'h0010_0000);
        // A foreign region wholly inside a usable one stops sanitise.
        send_command(make_cmd(CMD_ADD, 64'h7_4000_0000, 64'h1000_0000,
                              USABLE_TYPE, '0, '0));
        send_command(make_cmd(CMD_ADD, 64'h7_4100_0000, 64'h1000, 32'd2, '0, '0));
        send_command(make_cmd(CMD_SAN, '0, '0, '0, '0, '0));
        while (region_count < MRME_MAX_REGIONS)
            send_command(make_cmd(CMD_ADD, 64'h8000_0000_0000 + rand64() % 64'h1_0000,
                                  64'($urandom_range(1, 64)), 32'd3, '0, '0));
        send_command(make_cmd(CMD_ADD, '1, '1, '1, '0, '0));
        send_command(make_cmd(CMD_CARVE, 64'h7_4800_0000, 64'h1000, 32'd5, '0, '0));
        send_command(make_cmd(CMD_CARVE, 64'h7_4000_0000, 64'h1000, 32'd5, '0, '0));
        send_command(make_cmd(CMD_ADD, '0, '0, '0, '0, '0));
        send_command(make_cmd(CMD_READ, '0, '0, '0, '0, 8'hFF));
        send_command(make_cmd(CMD_SAN, '0, '0, '0, '0, '0));
        for (int n = 0; n < 20; n++) begin
            map_cmd_t c;
            c = random_command();
            if (c.cmd == CMD_SAN) c.cmd = CMD_READ;
            send_command(c);
        end
    endtask

    initial begin
        region_count = 0;
        bump_ptr  = BUMP_RESET;
        cfg_shift = PAGE_SHIFT_RESET;
        cfg_floor = LOW_FLOOR_RESET;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_empty_table();
        test_directed_map();
        test_random_traffic(400);
        test_output_backpressure();
        write_register(CFG_PAGE_SHIFT, 32'd0);
        write_register(CFG_LOW_FLOOR, 32'd0);
        test_random_traffic(400);
        write_register(CFG_PAGE_SHIFT, 32'd30);
        write_register(CFG_LOW_FLOOR, 32'hFFFF_FFFF);
        test_random_traffic(300);
        write_register(CFG_PAGE_SHIFT, $urandom_range(0, 30));
        write_register(CFG_LOW_FLOOR, $urandom);
        test_random_traffic(300);
        write_register(CFG_PAGE_SHIFT, 32'd12);
        write_register(CFG_LOW_FLOOR, 32'h0010_0000);
        test_random_traffic(50);
        test_full_table();

        wait_results();
        repeat (100) @(posedge aclk);
        errors += pending_results.size();
        if (errors == 0 && mismatches == 0) begin
            $display("memory_region_map_engine_unit_test OK");
        end else begin
            $display("memory_region_map_engine_unit_test NOT OK");
        end
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/mrme_pkg.sv
hw/rtl/mrme_dp.sv
hw/rtl/mrme_ctrl.sv
hw/rtl/memory_region_map_engine_unit.sv
tb/memory_region_map_engine_unit_test.sv
